@@ hdl/mi_pkg.sv @@
package mi_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

@@ hdl/mi_channels.sv @@
interface mi_cfg_if #(parameter int WORD_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

interface mi_value_if #(parameter int WORD_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface mi_inverse_if #(parameter int WORD_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] inverse;

  modport source (output valid, output inverse, input ready);
  modport sink   (input valid, input inverse, output ready);
endinterface

@@ hdl/modular_inverse.sv @@
// Channel   Direction  Payload             Meaning
// cfg       in         modulus [W-1:0]     modulus register, reset value 1
// operand   in         value   [W-1:0]     number to be inverted
// result    out        inverse [W-1:0]     value^-1 mod modulus (0 for modulus 0 or 1)
//
// Each Euclid round runs the restoring divide step and the shift-and-add
// modular multiply step side by side in ST_RUN, then updates the coefficient
// in ST_FIN. A full item takes about 46 rounds at most for 32-bit words; a
// modulus of 0 or 1 skips the rounds and goes straight to ST_DONE.
// Reset is synchronous and sets the modulus to 1. A new transaction is taken
// while the previous result still waits on the result channel; the block then
// holds its finished item in ST_DONE until that result has been taken.
module modular_inverse
  import mi_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  mi_cfg_if.sink          cfg,
  mi_value_if.sink        operand,
  mi_inverse_if.source    result
);

  localparam int CW = $clog2(WORD_BITS + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(WORD_BITS);

  state_t state, state_next;

  logic [WORD_BITS-1:0] modulus;
  logic [CW-1:0]        cnt;
  logic [WORD_BITS-1:0] a;
  logic [WORD_BITS-1:0] d;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] cur;
  logic [WORD_BITS-1:0] nxt;
  logic [WORD_BITS-1:0] prod;
  logic                 qbit;
  logic                 out_valid;
  logic [WORD_BITS-1:0] out_inverse;

  logic start, div_en, mul_en, next_round, deliver, trivial;

  // Divide step: shift one dividend bit into the partial remainder.
  logic [WORD_BITS:0]   div_x, div_diff;
  logic                 div_ge;

  // Multiply step: prod = 2*prod + qbit*nxt, reduced by up to two moduli.
  logic [WORD_BITS+1:0] mul_s, mul_s1, mul_s2, mul_n1, mul_n2, mul_next;

  logic [WORD_BITS-1:0] fin_sub, fin_nxt;

  assign trivial = (modulus[WORD_BITS-1:1] == '0);

  assign div_x    = {rem, a[WORD_BITS-1]};
  assign div_ge   = (div_x >= {1'b0, d});
  assign div_diff = div_x - {1'b0, d};

  assign mul_n1   = {2'b00, modulus};
  assign mul_n2   = {1'b0, modulus, 1'b0};
  assign mul_s    = {1'b0, prod, 1'b0} + (qbit ? {2'b00, nxt} : '0);
  assign mul_s1   = mul_s - mul_n1;
  assign mul_s2   = mul_s - mul_n2;

  always_comb begin
    if (mul_s >= mul_n2) begin
      mul_next = mul_s2;
    end else if (mul_s >= mul_n1) begin
      mul_next = mul_s1;
    end else begin
      mul_next = mul_s;
    end
  end

  // The difference wraps when negative; adding the modulus brings it back.
  assign fin_sub = cur - prod;
  assign fin_nxt = (cur >= prod) ? fin_sub : fin_sub + modulus;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (operand.valid) begin
          state_next = trivial ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt == LAST_STEP) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = (rem != '0) ? ST_RUN : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    start      = 1'b0;
    div_en     = 1'b0;
    mul_en     = 1'b0;
    next_round = 1'b0;
    deliver    = 1'b0;
    unique case (state)
      ST_IDLE: start = operand.valid;
      ST_RUN: begin
        div_en = (cnt != LAST_STEP);
        mul_en = (cnt != '0);
      end
      ST_FIN:  next_round = (rem != '0);
      ST_DONE: deliver = !out_valid || result.ready;
      default: ;
    endcase
  end

  assign operand.ready  = (state == ST_IDLE);
  assign cfg.ready      = 1'b1;
  assign result.valid   = out_valid;
  assign result.inverse = out_inverse;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      modulus   <= WORD_BITS'(1);
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        modulus <= cfg.modulus;
      end
      if (start || next_round) begin
        cnt <= '0;
      end else if (state == ST_RUN) begin
        cnt <= cnt + CW'(1);
      end
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= operand.value;
      d    <= modulus;
      cur  <= WORD_BITS'(1);
      nxt  <= '0;
      rem  <= '0;
      prod <= '0;
    end else if (next_round) begin
      a    <= d;
      d    <= rem;
      cur  <= nxt;
      nxt  <= fin_nxt;
      rem  <= '0;
      prod <= '0;
    end else begin
      if (div_en) begin
        rem  <= div_ge ? div_diff[WORD_BITS-1:0] : div_x[WORD_BITS-1:0];
        qbit <= div_ge;
        a    <= {a[WORD_BITS-2:0], 1'b0};
      end
      if (mul_en) begin
        prod <= mul_next[WORD_BITS-1:0];
      end
    end
    if (deliver) begin
      out_inverse <= nxt;
    end
  end

  a_trivial_skips: assert property (@(posedge clk) disable iff (rst)
    (operand.valid && operand.ready && trivial) |=> (state == ST_DONE && nxt == '0))
    else $error("modulus 0 or 1 must give an immediate zero result");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt <= LAST_STEP))
    else $error("step counter ran past the word width");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN || state == ST_FIN) |-> (rem < d))
    else $error("partial remainder not below divisor");

  a_residues_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN || state == ST_FIN) |-> (cur < modulus && nxt < modulus
                                              && prod < modulus))
    else $error("coefficient or product left unreduced");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !result.ready) |=> (state == ST_DONE))
    else $error("result overwritten while the previous one waits");

endmodule
